// ===== src/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants for the escape sequence decoder
// Status codes, character constants and the escape letter lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_LONE    = 2'd2,
        STATUS_SHORT   = 2'd3
    } status_t;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_ESCAPE    = 8'h1B;
    localparam logic [7:0] CHAR_CODE      = 8'h63;  // 'c'
    localparam logic [7:0] CHAR_ZERO      = 8'h30;  // '0'

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_map_t;

    // Map the letter after a backslash to its control byte.
    function automatic esc_map_t esc_lookup(input logic [7:0] ch);
        esc_map_t m;
        m.hit   = 1'b1;
        m.value = 8'h00;
        case (ch)
            8'h6E:          m.value = CHAR_NEWLINE;   // n
            CHAR_BACKSLASH: m.value = CHAR_BACKSLASH;
            8'h62:          m.value = 8'h08;          // b
            8'h65:          m.value = CHAR_ESCAPE;    // e
            8'h66:          m.value = 8'h0C;          // f
            8'h72:          m.value = 8'h0D;          // r
            8'h74:          m.value = 8'h09;          // t
            8'h76:          m.value = 8'h0B;          // v
            8'h61:          m.value = 8'h07;          // a
            default:        m.hit   = 1'b0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/esd_if.sv =====
// ----------------------------------------------------------------------------
// esd channel interfaces
// Valid/ready channels for escaped input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface esd_out_if
    import esd_pkg::*;
    ;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       done_res;
    status_t    status;

    modport source (output valid, output byte_valid, output byte_out,
                    output done_res, output status, input ready);
    modport sink   (input valid, input byte_valid, input byte_out,
                    input done_res, input status, output ready);
endinterface

`default_nettype wire

// ===== src/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder: backslash escape decoder, one byte per cycle while dout is ready
//
// Usage:
//   din carries one escaped byte per transaction (char_in) and a last flag
//   that closes a string. dout returns exactly one result per input
//   transaction, in order: byte_valid/byte_out hold a decoded byte (byte_out
//   is zero when no byte comes out), done_res copies last, and status flags
//   an unknown escape, a lone trailing backslash or a cut-short \c code.
//   A result appears on dout in the cycle after its input transaction.
//   Throughput: one transaction per cycle when dout is ready; the decode is
//   a single shallow pass from din into the result register, and the escape
//   state (mode, digit count, code accumulator) updates in the same cycle.
//   Stall: the result register holds while dout.ready is low; din.ready
//   stays high as long as the result register is empty or being drained.
//   Reset: rst_n (async, active low) empties the result register and puts
//   the decoder into text mode with a cleared code. After every last
//   transaction the state returns to the same values.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    esd_in_if.sink      din,
    esd_out_if.source   dout
);

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CODE = 2'd2
    } mode_t;

    mode_t      mode_reg,  mode_next;
    logic [1:0] digit_count_reg, digit_count_next;
    logic [7:0] code_accum_reg,  code_accum_next;

    logic       out_valid_reg;
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_out_reg,   byte_out_next;
    logic       done_res_reg;
    status_t    status_reg,     status_next;

    logic       accept;
    esc_map_t   esc;
    logic [7:0] code_sum;
    logic [1:0] count_inc;

    // Take a new byte whenever the result register is free or being drained.
    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    assign esc       = esc_lookup(din.char_in);
    // accum * 10 + (ch - '0'), all modulo 256
    assign code_sum  = {code_accum_reg[4:0], 3'b000} + {code_accum_reg[6:0], 1'b0}
                       + (din.char_in - CHAR_ZERO);
    assign count_inc = digit_count_reg + 2'd1;

    always_comb
    begin
        mode_next        = MODE_TEXT;
        digit_count_next = digit_count_reg;
        code_accum_next  = code_accum_reg;
        byte_valid_next  = 1'b0;
        byte_out_next    = 8'h00;
        status_next      = STATUS_OK;

        unique case (mode_reg)
            MODE_ESC:
            begin
                if (din.char_in == CHAR_CODE)
                begin
                    mode_next        = MODE_CODE;
                    digit_count_next = 2'd0;
                    code_accum_next  = 8'h00;
                    if (din.last)
                        status_next = STATUS_SHORT;
                end
                else if (esc.hit)
                begin
                    byte_valid_next = 1'b1;
                    byte_out_next   = esc.value;
                end
                else
                begin
                    status_next = STATUS_UNKNOWN;
                end
            end
            MODE_CODE:
            begin
                if (count_inc == 2'd3)
                begin
                    byte_valid_next  = 1'b1;
                    byte_out_next    = code_sum;
                    digit_count_next = 2'd0;
                    code_accum_next  = 8'h00;
                end
                else
                begin
                    mode_next        = MODE_CODE;
                    digit_count_next = count_inc;
                    code_accum_next  = code_sum;
                    if (din.last)
                        status_next = STATUS_SHORT;
                end
            end
            default:
            begin
                // Text mode; the unused code behaves the same.
                if (din.char_in == CHAR_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                    if (din.last)
                        status_next = STATUS_LONE;
                end
                else if (din.char_in != CHAR_NEWLINE)
                begin
                    byte_valid_next = 1'b1;
                    byte_out_next   = din.char_in;
                end
            end
        endcase

        // End of string: drop back to the reset state.
        if (din.last)
        begin
            mode_next        = MODE_TEXT;
            digit_count_next = 2'd0;
            code_accum_next  = 8'h00;
        end
    end

    // Control: decoder state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_TEXT;
            digit_count_reg <= 2'd0;
            code_accum_reg  <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                digit_count_reg <= digit_count_next;
                code_accum_reg  <= code_accum_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: load the result on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_valid_reg <= byte_valid_next;
            byte_out_reg   <= byte_out_next;
            done_res_reg   <= din.last;
            status_reg     <= status_next;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.byte_valid = byte_valid_reg;
    assign dout.byte_out   = byte_out_reg;
    assign dout.done_res   = done_res_reg;
    assign dout.status     = status_reg;

    // A string end always leaves the decoder in clean text mode.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && din.last) |=> (mode_reg == MODE_TEXT && digit_count_reg == 2'd0
                                  && code_accum_reg == 8'h00))
        else $error("decoder state not cleared after last");

    // Digits are only counted inside a \c code.
    a_count_in_code: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_count_reg != 2'd0) |-> (mode_reg == MODE_CODE))
        else $error("digit count set outside code mode");

    // End-of-string errors only appear on a final result.
    a_err_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_LONE || status_reg == STATUS_SHORT))
        |-> done_res_reg)
        else $error("end-of-string status without done_res");

    // No byte means a zero byte field.
    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> (byte_out_reg == 8'h00))
        else $error("byte_out nonzero without byte_valid");

endmodule

`default_nettype wire

// ===== test/escape_sequence_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder_tb: self-checking bench for the escape decoder
// Drives escaped byte strings into din, predicts every result from an
// independent model of the decoder, and compares each dout transaction field
// by field. The run steps through four flow-control phases on both channels.
// ----------------------------------------------------------------------------

module escape_sequence_decoder_tb;

    import esd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state as seen from outside: plain text, just after a backslash,
    // or collecting the three characters of a \c code.
    typedef enum logic [1:0] {
        DEC_TEXT   = 2'd0,
        DEC_ESCAPE = 2'd1,
        DEC_CODE   = 2'd2
    } dec_mode_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       done_res;
        status_t    status;
    } dec_result_t;

    // Letters that turn into a control byte after a backslash.
    localparam logic [7:0] ESC_LETTERS [9] = '{"n", CHAR_BACKSLASH, "b", "e", "f",
                                               "r", "t", "v", "a"};
    localparam int DRAIN_LIMIT = 20000;

    logic clk;
    logic rst_n;

    esd_in_if  din ();
    esd_out_if dout ();

    escape_sequence_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // Predictor state, mirrored from the decoder's behavior.
    dec_mode_t   dec_mode;
    logic [1:0]  code_digits;
    logic [7:0]  code_value;

    dec_result_t expected_results [$];
    dec_result_t want;
    logic [7:0]  pending_chars [$];

    int in_idle_pct;
    int out_stall_pct;
    int failures;
    int chars_sent;
    int strings_sent;
    int results_checked;
    int bytes_decoded;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: advance the mirrored state by one input byte and return the
    // result the decoder must produce for it.
    // ------------------------------------------------------------------------
    function automatic dec_result_t decode_char(input logic [7:0] ch, input logic fin);
        dec_result_t r;
        r.byte_valid = 1'b0;
        r.byte_out   = 8'h00;
        r.done_res   = fin;
        r.status     = STATUS_OK;
        case (dec_mode)
            DEC_ESCAPE:
            begin
                dec_mode     = DEC_TEXT;
                r.byte_valid = 1'b1;
                case (ch)
                    "n":            r.byte_out = CHAR_NEWLINE;
                    CHAR_BACKSLASH: r.byte_out = CHAR_BACKSLASH;
                    "b":            r.byte_out = 8'h08;
                    "e":            r.byte_out = CHAR_ESCAPE;
                    "f":            r.byte_out = 8'h0C;
                    "r":            r.byte_out = 8'h0D;
                    "t":            r.byte_out = 8'h09;
                    "v":            r.byte_out = 8'h0B;
                    "a":            r.byte_out = 8'h07;
                    CHAR_CODE:
                    begin
                        // Open a numeric code; ending the string here cuts it short.
                        r.byte_valid = 1'b0;
                        dec_mode     = DEC_CODE;
                        code_digits  = 2'd0;
                        code_value   = 8'h00;
                        if (fin)
                            r.status = STATUS_SHORT;
                    end
                    default:
                    begin
                        // Unknown escape, newline included: drop the byte, warn.
                        r.byte_valid = 1'b0;
                        r.status     = STATUS_UNKNOWN;
                    end
                endcase
            end
            DEC_CODE:
            begin
                // Any byte counts as a code character; wrap modulo 256.
                code_value  = 8'(code_value * 10 + ch - CHAR_ZERO);
                code_digits = code_digits + 2'd1;
                if (code_digits == 2'd3)
                begin
                    r.byte_valid = 1'b1;
                    r.byte_out   = code_value;
                    dec_mode     = DEC_TEXT;
                    code_digits  = 2'd0;
                    code_value   = 8'h00;
                end
                else if (fin)
                begin
                    r.status = STATUS_SHORT;
                end
            end
            default:
            begin
                dec_mode = DEC_TEXT;
                if (ch == CHAR_BACKSLASH)
                begin
                    dec_mode = DEC_ESCAPE;
                    if (fin)
                        r.status = STATUS_LONE;
                end
                else if (ch != CHAR_NEWLINE)
                begin
                    r.byte_valid = 1'b1;
                    r.byte_out   = ch;
                end
            end
        endcase
        // Every string starts from a clean decoder.
        if (fin)
        begin
            dec_mode    = DEC_TEXT;
            code_digits = 2'd0;
            code_value  = 8'h00;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle at random, then hold one byte on din until accepted and
    // queue its predicted result at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic drive_char(input logic [7:0] ch, input logic fin);
        while ($urandom_range(99) < in_idle_pct)
        begin
            // Keep the payload moving while idle so stale data is never trusted.
            din.valid   <= 1'b0;
            din.char_in <= 8'($urandom_range(255));
            din.last    <= 1'($urandom_range(1));
            @(posedge clk);
        end
        din.valid   <= 1'b1;
        din.char_in <= ch;
        din.last    <= fin;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        expected_results.push_back(decode_char(ch, fin));
        chars_sent++;
    endtask

    // Send the queued string, flagging its final byte as last.
    task automatic send_pending();
        foreach (pending_chars[i])
            drive_char(pending_chars[i], i == pending_chars.size() - 1);
        strings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Checker and receiver: compare each dout transaction with the oldest
    // prediction, then pick the next ready value.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: byte_valid %b byte_out %h done_res %b status %s",
                       dout.byte_valid, dout.byte_out, dout.done_res, dout.status.name());
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.byte_valid)
                    bytes_decoded++;
                if (dout.byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %b, actual %b", want.byte_valid,
                           dout.byte_valid);
                    failures++;
                end
                if (dout.byte_out !== want.byte_out)
                begin
                    $error("byte_out: expected %h, actual %h", want.byte_out, dout.byte_out);
                    failures++;
                end
                if (dout.done_res !== want.done_res)
                begin
                    $error("done_res: expected %b, actual %b", want.done_res, dout.done_res);
                    failures++;
                end
                if (dout.status !== want.status)
                begin
                    $error("status: expected %s, actual %s", want.status.name(),
                           dout.status.name());
                    failures++;
                end
            end
        end
        dout.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Directed strings: byte extremes, raw newline, a known escape, a code
    // that wraps and ends the string, non-digit code characters, unknown
    // escapes (newline among them), lone trailing backslash, and codes cut
    // short on the c and on the first character.
    // ------------------------------------------------------------------------
    task automatic test_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        // 256 wraps to zero and lands on the final byte of the string.
        pending_chars = '{8'h00, 8'hFF, CHAR_NEWLINE, CHAR_BACKSLASH, "n",
                          CHAR_BACKSLASH, CHAR_CODE, "2", "5", "6"};
        send_pending();
        pending_chars = '{CHAR_BACKSLASH, CHAR_CODE, 8'hFF, 8'h00, "9"};
        send_pending();
        pending_chars = '{CHAR_BACKSLASH, "q", CHAR_BACKSLASH, CHAR_NEWLINE};
        send_pending();
        pending_chars = '{CHAR_BACKSLASH};
        send_pending();
        pending_chars = '{CHAR_BACKSLASH, CHAR_CODE};
        send_pending();
        pending_chars = '{CHAR_BACKSLASH, CHAR_CODE, "1"};
        send_pending();
    endtask

    // ------------------------------------------------------------------------
    // Random strings under one flow-control setting. Most strings are built from
    // tokens (text, escapes, codes) with random content and are sometimes cut at a
    // random point, which ends them inside escapes and codes; the rest are raw noise.
    // ------------------------------------------------------------------------
    task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                       input int count);
        int         start;
        int         kind;
        int         cut;
        logic [7:0] ch;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        start         = chars_sent;
        while (chars_sent - start < count)
        begin
            pending_chars.delete();
            if ($urandom_range(99) < 12)
            begin
                repeat ($urandom_range(1, 10))
                    pending_chars.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    kind = $urandom_range(99);
                    if (kind < 35)
                    begin
                        ch = 8'($urandom_range(255));
                        if (ch == CHAR_BACKSLASH)
                            ch = CHAR_ZERO;
                        pending_chars.push_back(ch);
                    end
                    else if (kind < 42)
                    begin
                        pending_chars.push_back(CHAR_NEWLINE);
                    end
                    else if (kind < 60)
                    begin
                        pending_chars.push_back(CHAR_BACKSLASH);
                        pending_chars.push_back(ESC_LETTERS[$urandom_range(8)]);
                    end
                    else if (kind < 80)
                    begin
                        // Mostly decimal digits, sometimes any byte at all.
                        pending_chars.push_back(CHAR_BACKSLASH);
                        pending_chars.push_back(CHAR_CODE);
                        repeat (3)
                        begin
                            if ($urandom_range(3) == 0)
                                ch = 8'($urandom_range(255));
                            else
                                ch = 8'(CHAR_ZERO + $urandom_range(9));
                            pending_chars.push_back(ch);
                        end
                    end
                    else if (kind < 92)
                    begin
                        pending_chars.push_back(CHAR_BACKSLASH);
                        pending_chars.push_back(8'($urandom_range(255)));
                    end
                    else
                    begin
                        pending_chars.push_back(CHAR_BACKSLASH);
                        pending_chars.push_back(CHAR_NEWLINE);
                    end
                end
                if ($urandom_range(99) < 15)
                begin
                    cut = $urandom_range(1, pending_chars.size());
                    while (pending_chars.size() > cut)
                        void'(pending_chars.pop_back());
                end
            end
            send_pending();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        rst_n       = 1'b0;
        din.valid   = 1'b0;
        din.char_in = 8'h00;
        din.last    = 1'b0;
        dout.ready  = 1'b0;
        dec_mode    = DEC_TEXT;
        code_digits = 2'd0;
        code_value  = 8'h00;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        failures        = 0;
        chars_sent      = 0;
        strings_sent    = 0;
        results_checked = 0;
        bytes_decoded   = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_streams(0, 0, 285);
        test_random_streams(86, 0, 285);
        test_random_streams(0, 86, 285);
        test_random_streams(24, 24, 285);

        // Drop valid, then drain everything still in flight.
        din.valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            failures++;
        end
        // Keep the clock running to catch stray results that arrive after the drain.
        repeat (8) @(posedge clk);

        $display("Sent %0d strings (%0d bytes) through four flow-control phases;",
                 strings_sent, chars_sent);
        $display("checked %0d results, %0d of them carrying a decoded byte.",
                 results_checked, bytes_decoded);
        if (failures == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== escape_sequence_decoder.f =====
src/esd_pkg.sv
src/esd_if.sv
src/escape_sequence_decoder.sv
test/escape_sequence_decoder_tb.sv
